@@ rtl/i2crm_pkg.sv @@
// shared types and phase codes for the i2c register master
package i2crm_pkg;

	localparam int PHASE_W = 5;

	localparam logic [PHASE_W-1:0] PH_IDLE      = 5'd0;
	localparam logic [PHASE_W-1:0] PH_START_A   = 5'd1;
	localparam logic [PHASE_W-1:0] PH_TX_WADDR  = 5'd2;
	localparam logic [PHASE_W-1:0] PH_ACK_WADDR = 5'd3;
	localparam logic [PHASE_W-1:0] PH_TX_REG    = 5'd4;
	localparam logic [PHASE_W-1:0] PH_ACK_REG   = 5'd5;
	localparam logic [PHASE_W-1:0] PH_TX_DATA   = 5'd6;
	localparam logic [PHASE_W-1:0] PH_ACK_DATA  = 5'd7;
	localparam logic [PHASE_W-1:0] PH_START_B   = 5'd8;
	localparam logic [PHASE_W-1:0] PH_TX_RADDR  = 5'd9;
	localparam logic [PHASE_W-1:0] PH_ACK_RADDR = 5'd10;
	localparam logic [PHASE_W-1:0] PH_RX        = 5'd11;
	localparam logic [PHASE_W-1:0] PH_MACK      = 5'd12;
	localparam logic [PHASE_W-1:0] PH_STOP      = 5'd13;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_BURST = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	localparam logic [7:0] BURST_START_REG = 8'h03;
	localparam logic [7:0] DEV_ADDR_RESET  = 8'd60;

	typedef struct packed {
		logic       start_request;
		logic [1:0] operation;
		logic [7:0] register_address;
		logic [7:0] write_value;
		logic       sda_in;
	} tick_in_t;

	typedef struct packed {
		logic scl;
		logic sda_out;
		logic sda_drive;
		logic busy;
		logic done;
	} bus_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] reg_addr;
		logic [7:0] value;
	} cmd_t;

endpackage

@@ rtl/i2crm_step.sv @@
// transaction sequencer: one half-bit tick per step
module i2crm_step import i2crm_pkg::*; #(
	parameter int BURST_BYTES = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata,
	input  logic               step,
	input  tick_in_t           tick,
	output bus_t               bus,
	output logic [7:0]         read_byte,
	output logic signed [15:0] axis_x,
	output logic signed [15:0] axis_y,
	output logic signed [15:0] axis_z
);

	localparam int STORE = (BURST_BYTES > 6) ? BURST_BYTES : 6;
	localparam int IDX_W = $clog2(STORE);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BURST_BYTES - 1);

	logic [7:0]         dev_addr_q;
	logic [PHASE_W-1:0] phase_q, phase_d;
	logic [1:0]         tick_q, tick_d;
	logic [2:0]         bit_q, bit_d;
	logic [IDX_W-1:0]   byte_q, byte_d;
	logic [7:0]         shift_q, shift_d;
	cmd_t               cmd_q, cmd_d;
	logic [7:0]         rd_q, rd_d;
	logic [15:0]        ax_q, ax_d, ay_q, ay_d, az_q, az_d;
	logic [7:0]         burst_mem [STORE];
	logic               burst_we;
	logic [7:0]         rx_byte;
	logic [PHASE_W-1:0] ph;
	logic [1:0]         t;
	logic               last;
	bus_t               b;

	always_comb begin
		phase_d  = phase_q;
		tick_d   = tick_q;
		bit_d    = bit_q;
		byte_d   = byte_q;
		shift_d  = shift_q;
		cmd_d    = cmd_q;
		rd_d     = rd_q;
		ax_d     = ax_q;
		ay_d     = ay_q;
		az_d     = az_q;
		burst_we = 1'b0;
		rx_byte  = {shift_q[6:0], tick.sda_in};
		last     = 1'b0;
		b        = '{scl: 1'b1, sda_out: 1'b1, sda_drive: 1'b1, busy: 1'b0, done: 1'b0};
		ph       = phase_q;
		t        = tick_q;
		if (phase_q == PH_IDLE && tick.start_request && tick.operation != OP_NONE) begin
			cmd_d   = '{op: tick.operation, reg_addr: tick.register_address,
				value: tick.write_value};
			byte_d  = '0;
			bit_d   = '0;
			shift_d = '0;
			ph      = PH_START_A;
			t       = 2'd0;
			rx_byte = {7'd0, tick.sda_in};
		end
		if (ph != PH_IDLE) begin
			b.busy = 1'b1;
			case (ph)
				PH_START_A, PH_START_B: begin
					b.sda_out = (t == 2'd0);
					if (t != 2'd0) begin
						phase_d = (ph == PH_START_A) ? PH_TX_WADDR : PH_TX_RADDR;
						tick_d  = 2'd0;
						bit_d   = '0;
						shift_d = (ph == PH_START_A) ? dev_addr_q : dev_addr_q + 8'd1;
					end else begin
						phase_d = ph;
						tick_d  = 2'd1;
					end
				end
				PH_TX_WADDR, PH_TX_REG, PH_TX_DATA, PH_TX_RADDR: begin
					b.sda_out = shift_d[7];
					b.scl     = (t == 2'd1);
					phase_d   = ph;
					if (t[1]) begin
						tick_d  = 2'd0;
						if (bit_d == 3'd7) begin
							phase_d = ph + 5'd1;
							bit_d   = '0;
							shift_d = '0;
						end else begin
							bit_d   = bit_d + 3'd1;
							shift_d = {shift_d[6:0], 1'b0};
						end
					end else begin
						tick_d = t + 2'd1;
					end
				end
				PH_ACK_WADDR, PH_ACK_REG, PH_ACK_DATA, PH_ACK_RADDR: begin
					b.sda_drive = 1'b0;
					b.scl       = (t == 2'd0);
					phase_d     = ph;
					if (t != 2'd0) begin
						tick_d = 2'd0;
						bit_d  = '0;
						case (ph)
							PH_ACK_WADDR: begin
								phase_d = PH_TX_REG;
								shift_d = (cmd_d.op == OP_BURST) ? BURST_START_REG
									: cmd_d.reg_addr;
							end
							PH_ACK_REG: begin
								phase_d = (cmd_d.op == OP_WRITE) ? PH_TX_DATA : PH_START_B;
								shift_d = cmd_d.value;
							end
							PH_ACK_DATA: begin
								phase_d = PH_STOP;
								shift_d = '0;
							end
							default: begin
								phase_d = PH_RX;
								shift_d = '0;
							end
						endcase
					end else begin
						tick_d = 2'd1;
					end
				end
				PH_RX: begin
					b.sda_drive = 1'b0;
					b.scl       = (t == 2'd1);
					phase_d     = ph;
					if (t != 2'd0) begin
						shift_d = rx_byte;
						tick_d  = 2'd0;
						if (bit_d == 3'd7) begin
							burst_we = (cmd_d.op == OP_BURST);
							phase_d  = PH_MACK;
							bit_d    = '0;
						end else begin
							bit_d = bit_d + 3'd1;
						end
					end else begin
						tick_d = 2'd1;
					end
				end
				PH_MACK: begin
					last      = (cmd_d.op != OP_BURST) || (byte_d >= LAST_IDX);
					b.sda_out = last;
					b.scl     = (t == 2'd1);
					phase_d   = ph;
					if (t != 2'd0) begin
						tick_d = 2'd0;
						bit_d  = '0;
						if (last) begin
							phase_d = PH_STOP;
						end else begin
							byte_d  = byte_d + IDX_W'(1);
							phase_d = PH_RX;
							shift_d = '0;
						end
					end else begin
						tick_d = 2'd1;
					end
				end
				default: begin
					b.scl     = (t != 2'd0);
					b.sda_out = t[1];
					phase_d   = ph;
					if (t[1] || ph != PH_STOP) begin
						b.done = 1'b1;
						if (cmd_d.op == OP_READ) begin
							rd_d = shift_d;
						end else if (cmd_d.op == OP_BURST) begin
							ax_d = {burst_mem[1], burst_mem[0]};
							ay_d = {burst_mem[3], burst_mem[2]};
							az_d = {burst_mem[5], burst_mem[4]};
						end
						phase_d = PH_IDLE;
						tick_d  = 2'd0;
						bit_d   = '0;
						shift_d = '0;
						byte_d  = '0;
					end else begin
						tick_d = t + 2'd1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= DEV_ADDR_RESET;
		end else if (cfg_we) begin
			dev_addr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			bit_q   <= '0;
			byte_q  <= '0;
			shift_q <= '0;
			cmd_q   <= '0;
			rd_q    <= '0;
			ax_q    <= '0;
			ay_q    <= '0;
			az_q    <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			bit_q   <= bit_d;
			byte_q  <= byte_d;
			shift_q <= shift_d;
			cmd_q   <= cmd_d;
			rd_q    <= rd_d;
			ax_q    <= ax_d;
			ay_q    <= ay_d;
			az_q    <= az_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && burst_we) begin
			burst_mem[byte_q] <= rx_byte;
		end
	end

	assign bus       = b;
	assign read_byte = rd_d;
	assign axis_x    = signed'(ax_d);
	assign axis_y    = signed'(ay_d);
	assign axis_z    = signed'(az_d);

endmodule

@@ rtl/i2c_register_master_top.sv @@
// i2c register master top level: input register, sequencer, result register
// Each input beat is one half-bit tick from an external prescaler and yields
// exactly one result beat with the bus levels, busy and done flags, and the
// latest read results. One tick is accepted every clock cycle while the result
// register is not stalled; a tick is held in the input register and its result
// beat in the result register, and the sequencer state advances once per tick
// in a single pass of logic. A write takes 83 ticks, a single read 103 ticks, and
// a burst read of BURST_BYTES bytes 85 + 18 * BURST_BYTES ticks, stop included.
// read_byte and the axis words change on the done beat. The slave address
// register may be written only while no transaction is running.
module i2c_register_master_top import i2crm_pkg::*; #(
	parameter int BURST_BYTES = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // register_address, write_value, sda_in, zero pad
	input  logic [2:0]  s_tuser,  // start_request, operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata   // scl, sda_out, sda_drive, busy_res, done_res,
	                              // read_byte, axis_x, axis_y, axis_z, zero pad
);

	logic               valid_s1;
	tick_in_t           tick_s1;
	logic               advance;
	bus_t               bus;
	logic [7:0]         read_byte;
	logic signed [15:0] axis_x, axis_y, axis_z;
	logic               valid_s2;
	logic [60:0]        data_s2;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			tick_s1 <= '{start_request: s_tuser[0], operation: s_tuser[2:1],
				register_address: s_tdata[7:0], write_value: s_tdata[15:8],
				sda_in: s_tdata[16]};
		end
	end

	i2crm_step #(
		.BURST_BYTES(BURST_BYTES)
	) u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.step     (advance),
		.tick     (tick_s1),
		.bus      (bus),
		.read_byte(read_byte),
		.axis_x   (axis_x),
		.axis_y   (axis_y),
		.axis_z   (axis_z)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s2 <= {axis_z, axis_y, axis_x, read_byte,
				bus.done, bus.busy, bus.sda_drive, bus.sda_out, bus.scl};
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {3'd0, data_s2};

	// done only inside a transaction, with the stop levels on the bus
	a_done_levels: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && data_s2[4] |-> data_s2[3] && data_s2[0] && data_s2[1] && data_s2[2])
		else $error("done beat without busy or stop levels");

	// released sda reads high
	a_release_high: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !data_s2[2] |-> data_s2[1])
		else $error("sda released but driven low");

	// idle bus levels
	a_idle_bus: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !data_s2[3] |-> data_s2[0] && data_s2[1] && data_s2[2] && !data_s2[4])
		else $error("idle beat with bus activity");

	// a stalled result register holds while the next tick waits in the input register
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !m_tready |=> valid_s2 && $stable(data_s2) && !$past(advance))
		else $error("result changed while stalled");

endmodule

@@ tb/sv/i2c_register_master_top_tb.sv @@
// self-checking testbench for the i2c register master: tick-level bus and read-data prediction
`timescale 1ns / 1ps

module i2c_register_master_top_tb;
	import i2crm_pkg::*;

	localparam int N_BURST     = 6;
	localparam int STALL_LIMIT = 5000;

	// result beat as packed on m_tdata, lowest field last
	typedef struct packed {
		logic [15:0] axis_z;
		logic [15:0] axis_y;
		logic [15:0] axis_x;
		logic [7:0]  read_byte;
		logic        done;
		logic        busy;
		logic        drive;
		logic        sda;
		logic        scl;
	} beat_t;

	class bus_level_checker;
		logic [7:0]  dev_addr;
		logic [4:0]  phase;
		logic [1:0]  tip;
		logic [2:0]  bit_cnt;
		logic [2:0]  byte_cnt;
		logic [7:0]  shreg;
		logic [7:0]  burst [N_BURST];
		cmd_t        cmd;
		logic [7:0]  rd_byte;
		logic [15:0] ax, ay, az;
		beat_t       pending_levels [$];
		int          fail_count;

		function new();
			dev_addr = DEV_ADDR_RESET;
			phase = PH_IDLE;
			tip = '0;
			bit_cnt = '0;
			byte_cnt = '0;
			shreg = '0;
			cmd = '0;
			rd_byte = '0;
			ax = '0;
			ay = '0;
			az = '0;
			fail_count = 0;
		endfunction

		function bit idle();
			return phase == PH_IDLE;
		endfunction

		function void enter(logic [4:0] nxt, logic [7:0] load);
			phase = nxt;
			tip = '0;
			bit_cnt = '0;
			shreg = load;
		endfunction

		function void take_tick(tick_in_t t);
			beat_t r;
			logic  lst;
			r = '0;
			r.scl = 1'b1;
			r.sda = 1'b1;
			r.drive = 1'b1;
			if (phase == PH_IDLE && t.start_request && t.operation != OP_NONE) begin
				cmd.op = t.operation;
				cmd.reg_addr = t.register_address;
				cmd.value = t.write_value;
				byte_cnt = '0;
				enter(PH_START_A, 8'd0);
			end
			if (phase != PH_IDLE) begin
				r.busy = 1'b1;
				case (phase)
					PH_START_A, PH_START_B: begin
						r.sda = (tip == 0);
						if (tip >= 1) begin
							if (phase == PH_START_A) enter(PH_TX_WADDR, dev_addr);
							else enter(PH_TX_RADDR, dev_addr + 8'd1);
						end else tip = 2'd1;
					end
					PH_TX_WADDR, PH_TX_REG, PH_TX_DATA, PH_TX_RADDR: begin
						r.sda = shreg[7];
						r.scl = (tip == 1);
						if (tip >= 2) begin
							shreg = shreg << 1;
							tip = '0;
							if (bit_cnt >= 7) enter(phase + 5'd1, 8'd0);
							else bit_cnt = bit_cnt + 3'd1;
						end else tip = tip + 2'd1;
					end
					PH_ACK_WADDR, PH_ACK_REG, PH_ACK_DATA, PH_ACK_RADDR: begin
						r.drive = 1'b0;
						r.scl = (tip == 0);
						if (tip >= 1) begin
							if (phase == PH_ACK_WADDR)
								enter(PH_TX_REG, cmd.op == OP_BURST ? BURST_START_REG : cmd.reg_addr);
							else if (phase == PH_ACK_REG)
								enter(cmd.op == OP_WRITE ? PH_TX_DATA : PH_START_B, cmd.value);
							else if (phase == PH_ACK_DATA)
								enter(PH_STOP, 8'd0);
							else
								enter(PH_RX, 8'd0);
						end else tip = 2'd1;
					end
					PH_RX: begin
						r.drive = 1'b0;
						r.scl = (tip == 1);
						if (tip >= 1) begin
							shreg = {shreg[6:0], t.sda_in};
							tip = '0;
							if (bit_cnt >= 7) begin
								if (cmd.op == OP_BURST) burst[byte_cnt] = shreg;
								phase = PH_MACK;
								bit_cnt = '0;
							end else bit_cnt = bit_cnt + 3'd1;
						end else tip = 2'd1;
					end
					PH_MACK: begin
						lst = (cmd.op != OP_BURST) || (byte_cnt >= N_BURST - 1);
						r.sda = lst;
						r.scl = (tip == 1);
						if (tip >= 1) begin
							if (lst) enter(PH_STOP, shreg);
							else begin
								byte_cnt = byte_cnt + 3'd1;
								enter(PH_RX, 8'd0);
							end
						end else tip = 2'd1;
					end
					default: begin
						r.scl = (tip >= 1);
						r.sda = (tip >= 2);
						if (tip >= 2 || phase != PH_STOP) begin
							r.done = 1'b1;
							if (cmd.op == OP_READ) rd_byte = shreg;
							else if (cmd.op == OP_BURST) begin
								ax = {burst[1], burst[0]};
								ay = {burst[3], burst[2]};
								az = {burst[5], burst[4]};
							end
							enter(PH_IDLE, 8'd0);
							byte_cnt = '0;
						end else tip = tip + 2'd1;
					end
				endcase
			end
			r.read_byte = rd_byte;
			r.axis_x = ax;
			r.axis_y = ay;
			r.axis_z = az;
			pending_levels.push_back(r);
		endfunction

		function void compare(string name, logic [15:0] want, logic [15:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				fail_count++;
			end
		endfunction

		function void check_beat(logic [63:0] d);
			beat_t got;
			beat_t want;
			got = d[60:0];
			if (pending_levels.size() == 0) begin
				$error("result beat with no expectation pending: %0h", d);
				fail_count++;
				return;
			end
			want = pending_levels.pop_front();
			compare("scl", want.scl, got.scl);
			compare("sda_out", want.sda, got.sda);
			compare("sda_drive", want.drive, got.drive);
			compare("busy_res", want.busy, got.busy);
			compare("done_res", want.done, got.done);
			compare("read_byte", want.read_byte, got.read_byte);
			compare("axis_x", want.axis_x, got.axis_x);
			compare("axis_y", want.axis_y, got.axis_y);
			compare("axis_z", want.axis_z, got.axis_z);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;

	bus_level_checker sb = new();
	int               src_idle_pct = 0;
	int               rcv_idle_pct = 0;
	bit               allow_pause = 1'b0;
	int               stall_cycles = 0;
	logic [7:0]       slave_bytes [N_BURST];

	i2c_register_master_top #(.BURST_BYTES(N_BURST)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (m_tvalid && m_tready) sb.check_beat(m_tdata);
		m_tready <= ($urandom_range(99) >= rcv_idle_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic wait_drained();
		while (sb.pending_levels.size() != 0) @(posedge clk);
	endtask

	task automatic send_tick(input tick_in_t t);
		if (allow_pause && $urandom_range(499) == 0) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			wait_drained();
		end
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, t.sda_in, t.write_value, t.register_address};
		s_tuser <= {t.operation, t.start_request};
		do @(posedge clk); while (!s_tready);
		sb.take_tick(t);
	endtask

	// beats with no transaction started; a request here carries the unused opcode
	task automatic idle_ticks(input int n);
		tick_in_t t;
		repeat (n) begin
			t.start_request = 1'($urandom);
			t.operation = t.start_request ? OP_NONE : 2'($urandom);
			t.register_address = 8'($urandom);
			t.write_value = 8'($urandom);
			t.sda_in = 1'($urandom);
			send_tick(t);
		end
	endtask

	task automatic run_txn(input logic [1:0] op, input logic [7:0] ra, input logic [7:0] val,
			input bit noisy);
		tick_in_t t;
		t.start_request = 1'b1;
		t.operation = op;
		t.register_address = ra;
		t.write_value = val;
		t.sda_in = 1'($urandom);
		send_tick(t);
		while (!sb.idle()) begin
			t.start_request = noisy ? 1'($urandom) : 1'b0;
			t.operation = 2'($urandom);
			t.register_address = 8'($urandom);
			t.write_value = 8'($urandom);
			if (sb.phase == PH_RX) t.sda_in = slave_bytes[sb.byte_cnt][3'd7 - sb.bit_cnt];
			else t.sda_in = 1'($urandom);
			send_tick(t);
		end
	endtask

	task automatic set_dev_addr(input logic [7:0] v);
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.dev_addr = v;
	endtask

	task automatic fill_slave_random();
		foreach (slave_bytes[i]) slave_bytes[i] = 8'($urandom);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		allow_pause = 1'b1;

		// sender idles lightly, receiver heavily, reset slave address
		src_idle_pct = 9;
		rcv_idle_pct = 74;
		fill_slave_random();
		run_txn(OP_NONE, 8'h12, 8'h34, 1'b0);
		idle_ticks(3);
		run_txn(OP_WRITE, 8'hFF, 8'h00, 1'b1);

		// read address wraps to zero
		src_idle_pct = 74;
		rcv_idle_pct = 9;
		set_dev_addr(8'hFF);
		slave_bytes = '{8'hA5, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
		run_txn(OP_READ, 8'h7F, 8'h55, 1'b0);

		// signed burst words
		src_idle_pct = 0;
		rcv_idle_pct = 0;
		set_dev_addr(8'($urandom_range(254)));
		slave_bytes = '{8'h00, 8'h80, 8'hFF, 8'h7F, 8'h01, 8'h80};
		run_txn(OP_BURST, 8'h00, 8'h00, 1'b1);
		allow_pause = 1'b0;

		s_tvalid <= 1'b0;
		wait_drained();
		repeat (8) @(posedge clk);
		if (sb.fail_count == 0 && sb.pending_levels.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
